// ----- hw/rtl/mipf_pkg.sv -----
`timescale 1ns / 1ps

package mipf_pkg;

  // Smallest modulus that defines a field; anything below gives a flagged zero
  localparam int unsigned MIN_MODULUS = 2;

  // Main sequencer states
  typedef enum logic [5:0] {
    S_IDLE   = 6'b000001,
    S_REDUCE = 6'b000010,
    S_LAUNCH = 6'b000100,
    S_DIV    = 6'b001000,
    S_FOLD   = 6'b010000,
    S_FINISH = 6'b100000
  } state_t;

  // Divide unit phases
  typedef enum logic [2:0] {
    DP_IDLE  = 3'b001,
    DP_ALIGN = 3'b010,
    DP_SUB   = 3'b100
  } div_phase_t;

  // Sequencer to divide unit
  typedef struct packed {
    logic start;
  } div_ctrl_t;

  // Divide unit to sequencer
  typedef struct packed {
    logic done;
  } div_stat_t;

endpackage

// ----- hw/rtl/mipf_divstep.sv -----
`timescale 1ns / 1ps

// Shared shift-subtract divide unit. Aligns the divisor under the dividend,
// then retires one quotient bit per cycle. While the quotient bits come out
// (MSB first) it accumulates quotient * mult, so the Euclid coefficient
// update needs no multiplier.
module mipf_divstep #(
  parameter int MOD_BITS = 31
) (
  input  logic                      clk,
  input  logic                      rst,
  input  mipf_pkg::div_ctrl_t       ctrl,
  input  logic [MOD_BITS-1:0]       dividend,
  input  logic [MOD_BITS-1:0]       divisor,
  input  logic signed [MOD_BITS:0]  mult,
  output mipf_pkg::div_stat_t       stat,
  output logic [MOD_BITS-1:0]       remainder,
  output logic signed [MOD_BITS:0]  product
);

  localparam int KW = $clog2(MOD_BITS);

  mipf_pkg::div_phase_t phase;
  logic                      done;
  logic [MOD_BITS-1:0]       rem;
  logic [MOD_BITS-1:0]       dsh;
  logic [KW-1:0]             k;
  logic signed [MOD_BITS:0]  mul;
  logic signed [MOD_BITS:0]  acc;

  logic [MOD_BITS:0]         cand;
  logic [MOD_BITS:0]         diff;
  logic                      ge;
  logic signed [MOD_BITS:0]  acc_next;

  // Trial alignment, trial subtract and product accumulate
  always_comb begin
    cand     = {dsh, 1'b0};
    diff     = {1'b0, rem} - {1'b0, dsh};
    ge       = ~diff[MOD_BITS];
    acc_next = {acc[MOD_BITS-1:0], 1'b0} + (ge ? mul : '0);
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      phase <= mipf_pkg::DP_IDLE;
      done  <= 1'b0;
    end else begin
      done <= 1'b0;
      case (phase)
        mipf_pkg::DP_IDLE: begin
          if (ctrl.start) begin
            rem   <= dividend;
            dsh   <= divisor;
            mul   <= mult;
            acc   <= '0;
            k     <= '0;
            phase <= mipf_pkg::DP_ALIGN;
          end
        end
        // shift divisor up while the doubled value still fits
        mipf_pkg::DP_ALIGN: begin
          if (cand <= {1'b0, rem}) begin
            dsh <= cand[MOD_BITS-1:0];
            k   <= k + 1'b1;
          end else begin
            phase <= mipf_pkg::DP_SUB;
          end
        end
        // one quotient bit per cycle
        mipf_pkg::DP_SUB: begin
          if (ge) begin
            rem <= diff[MOD_BITS-1:0];
          end
          acc <= acc_next;
          if (k == '0) begin
            phase <= mipf_pkg::DP_IDLE;
            done  <= 1'b1;
          end else begin
            dsh <= dsh >> 1;
            k   <= k - 1'b1;
          end
        end
        default: begin
          phase <= mipf_pkg::DP_IDLE;
        end
      endcase
    end
  end

  assign stat.done = done;
  assign remainder = rem;
  assign product   = acc;

endmodule

// ----- hw/rtl/modular_inverse_prime_field.sv -----
`timescale 1ns / 1ps

// Modular inverse in GF(p) by the extended Euclidean algorithm, p held in a
// write-only register (reset value all ones). Each input transaction yields
// one output transaction: the inverse in 0..p-1, or 0 with not_invertible set
// when the operand is a multiple of p or p is below two. One operand is
// processed at a time and in_stall stays high until the result has been
// moved to the output register; an output still waiting does not block the
// next operand. The single shift-subtract divide unit performs both the initial
// reduction and every Euclid step.
module modular_inverse_prime_field #(
  parameter int MOD_BITS = 31
) (
  input  logic                clk,
  input  logic                rst,
  input  logic                cfg_valid,
  output logic                cfg_ready,
  input  logic [MOD_BITS-1:0] modulus,
  input  logic                in_valid,
  output logic                in_stall,
  input  logic [MOD_BITS-1:0] value,
  output logic                out_valid,
  input  logic                out_stall,
  output logic [MOD_BITS-1:0] inverse,
  output logic                not_invertible
);

  mipf_pkg::state_t state;
  logic [MOD_BITS-1:0]       prime;
  logic [MOD_BITS-1:0]       r;
  logic [MOD_BITS-1:0]       nr;
  logic signed [MOD_BITS:0]  t;
  logic signed [MOD_BITS:0]  nt;
  logic [MOD_BITS-1:0]       res_inv;
  logic                      res_flag;

  mipf_pkg::div_ctrl_t       div_ctrl;
  mipf_pkg::div_stat_t       div_stat;
  logic [MOD_BITS-1:0]       div_dividend;
  logic [MOD_BITS-1:0]       div_divisor;
  logic signed [MOD_BITS:0]  div_mult;
  logic [MOD_BITS-1:0]       div_rem;
  logic signed [MOD_BITS:0]  div_prod;

  logic                      small_mod;
  logic [MOD_BITS+1:0]       t_sub;
  logic [MOD_BITS:0]         t_fold;

  assign cfg_ready = 1'b1;
  assign in_stall  = (state != mipf_pkg::S_IDLE);
  assign small_mod = (prime < MOD_BITS'(mipf_pkg::MIN_MODULUS));

  // Divide unit operand select: reduction on accept, Euclid step on launch
  always_comb begin
    div_ctrl.start = 1'b0;
    div_dividend   = r;
    div_divisor    = nr;
    div_mult       = nt;
    case (state)
      mipf_pkg::S_IDLE: begin
        if (in_valid && !small_mod) begin
          div_ctrl.start = 1'b1;
          div_dividend   = value;
          div_divisor    = prime;
          div_mult       = '0;
        end
      end
      mipf_pkg::S_LAUNCH: begin
        div_ctrl.start = 1'b1;
      end
      default: begin
        div_ctrl.start = 1'b0;
      end
    endcase
  end

  // Coefficient update t - q*nt and final fold of a negative coefficient
  always_comb begin
    t_sub  = {t[MOD_BITS], t} - {div_prod[MOD_BITS], div_prod};
    t_fold = t + {1'b0, prime};
  end

  mipf_divstep #(
    .MOD_BITS (MOD_BITS)
  ) u_divstep (
    .clk       (clk),
    .rst       (rst),
    .ctrl      (div_ctrl),
    .dividend  (div_dividend),
    .divisor   (div_divisor),
    .mult      (div_mult),
    .stat      (div_stat),
    .remainder (div_rem),
    .product   (div_prod)
  );

  // Sequencer, Euclid registers and output register
  always_ff @(posedge clk) begin
    if (rst) begin
      state     <= mipf_pkg::S_IDLE;
      out_valid <= 1'b0;
      prime     <= '1;
    end else begin
      if (cfg_valid && cfg_ready) begin
        prime <= modulus;
      end
      // output valid: set on a load, cleared once taken
      if (state == mipf_pkg::S_FINISH && (!out_valid || !out_stall)) begin
        out_valid <= 1'b1;
      end else if (out_valid && !out_stall) begin
        out_valid <= 1'b0;
      end
      case (state)
        mipf_pkg::S_IDLE: begin
          if (in_valid) begin
            if (small_mod) begin
              res_inv  <= '0;
              res_flag <= 1'b1;
              state    <= mipf_pkg::S_FINISH;
            end else begin
              state <= mipf_pkg::S_REDUCE;
            end
          end
        end
        // operand mod p; zero residue has no inverse
        mipf_pkg::S_REDUCE: begin
          if (div_stat.done) begin
            if (div_rem == '0) begin
              res_inv  <= '0;
              res_flag <= 1'b1;
              state    <= mipf_pkg::S_FINISH;
            end else begin
              r     <= prime;
              nr    <= div_rem;
              t     <= '0;
              nt    <= (MOD_BITS+1)'(1);
              state <= mipf_pkg::S_LAUNCH;
            end
          end
        end
        mipf_pkg::S_LAUNCH: begin
          state <= mipf_pkg::S_DIV;
        end
        // one Euclid step retires
        mipf_pkg::S_DIV: begin
          if (div_stat.done) begin
            t  <= nt;
            nt <= t_sub[MOD_BITS:0];
            r  <= nr;
            nr <= div_rem;
            if (div_rem == '0) begin
              state <= mipf_pkg::S_FOLD;
            end else begin
              state <= mipf_pkg::S_LAUNCH;
            end
          end
        end
        mipf_pkg::S_FOLD: begin
          res_inv  <= t[MOD_BITS] ? t_fold[MOD_BITS-1:0] : t[MOD_BITS-1:0];
          res_flag <= 1'b0;
          state    <= mipf_pkg::S_FINISH;
        end
        // hand result to output register once it is free
        mipf_pkg::S_FINISH: begin
          if (!out_valid || !out_stall) begin
            inverse        <= res_inv;
            not_invertible <= res_flag;
            state          <= mipf_pkg::S_IDLE;
          end
        end
        default: begin
          state <= mipf_pkg::S_IDLE;
        end
      endcase
    end
  end

endmodule
